>>> sv/spkd_pkg.sv
// ----------------------------------------------------------------------------
// Spike count difference distance: shared package
// Field widths, operation codes and the control bundle of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spkd_pkg;

   localparam int SPIKE_W  = 32;
   localparam int OPCODE_W = 2;
   localparam int DIST_W   = 46;

   localparam logic [OPCODE_W-1:0] OP_ADD_REF   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_TEST  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_REF = 2'd3;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic acc;     // add one partial product
      logic hi;      // use the upper half of the gap, weighted by the split point
   } mac_ctl_type;

endpackage

`default_nettype wire

>>> sv/spkd_if.sv
// ----------------------------------------------------------------------------
// Spike count difference distance: channel interfaces
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface spkd_req_if;
   logic                             valid;
   logic                             ready;
   logic [spkd_pkg::OPCODE_W-1:0]    opcode;
   logic [spkd_pkg::SPIKE_W-1:0]     spike_time;

   modport source (output valid, output opcode, output spike_time, input ready);
   modport sink   (input valid, input opcode, input spike_time, output ready);
endinterface

interface spkd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [spkd_pkg::DIST_W-1:0] distance;
   logic                             train_overflow;

   modport source (output valid, output distance, output train_overflow, input ready);
   modport sink   (input valid, input distance, input train_overflow, output ready);
endinterface

`default_nettype wire

>>> sv/spkd_ram.sv
// ----------------------------------------------------------------------------
// Spike train store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spkd_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> sv/spkd_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies a signed time gap by a squared count difference in two halves
// and accumulates the products modulo 2^46.
// ----------------------------------------------------------------------------
`default_nettype none

module spkd_mac #(
   parameter int GW  = 33,
   parameter int SQW = 14
) (
   input  wire logic                              clock,
   input  wire logic signed [GW-1:0]              gap,
   input  wire logic        [SQW-1:0]             fac,
   input  wire spkd_pkg::mac_ctl_type             ctl,
   output logic signed [spkd_pkg::DIST_W-1:0]     sum
);

   localparam int LB = (GW + 1) / 2;
   localparam int PW = LB + SQW + 2;
   localparam int DW = spkd_pkg::DIST_W;

   logic signed [LB:0]     opa;
   logic signed [SQW:0]    opb;
   logic signed [PW-1:0]   prod;
   logic signed [DW-1:0]   prod_ext;
   logic signed [DW-1:0]   addend;
   logic signed [DW-1:0]   sum_ff;
   logic signed [DW-1:0]   sum_in;

   always_comb begin
      if (ctl.hi) begin
         opa = (LB+1)'($signed(gap[GW-1:LB]));
      end else begin
         opa = $signed({1'b0, gap[LB-1:0]});
      end
      opb      = $signed({1'b0, fac});
      prod     = PW'(opa * opb);
      prod_ext = DW'(prod);
      addend   = ctl.hi ? (prod_ext <<< LB) : prod_ext;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.acc) begin
         sum_in = sum_ff + addend;
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

>>> sv/spike_count_difference_distance_top.sv
// ----------------------------------------------------------------------------
// Spike count difference distance
// Stores a reference and a test spike train and integrates the squared
// running count difference over the merged train up to the window end.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    opcode, spike_time
//   rsp_if    out        valid/ready    distance, train_overflow
//   csr       in         csr_we         csr_wdata (time_length)
//
// Adding a spike or clearing the reference train leaves the block idle, so such
// items are taken back to back. A compute walks the merged trains through one
// shared multiplier: each stored spike passes READ, PICK, MUL_LO and MUL_HI,
// then the tail passes TAIL, MUL_LO and MUL_HI before DONE (DONE straight away
// if both trains are empty). A finished result waits in the output register; a
// later compute holds in its last step until that result is taken. Reset is
// synchronous and clears the counts, the overflow flag and time_length.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_count_difference_distance_top #(
   parameter int MAX_SPIKES = 64,
   parameter int TIME_BITS  = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   spkd_req_if.sink                            req_if,
   spkd_rsp_if.source                          rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [spkd_pkg::SPIKE_W-1:0]   csr_wdata
);

   localparam int TW  = (TIME_BITS < spkd_pkg::SPIKE_W) ? TIME_BITS : spkd_pkg::SPIKE_W;
   localparam int GW  = TW + 1;
   localparam int CW  = $clog2(MAX_SPIKES + 1);
   localparam int AW  = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
   localparam int SQW = 2 * CW;
   localparam int DW  = spkd_pkg::DIST_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_MUL_LO = 3'd3;
   localparam logic [2:0] S_MUL_HI = 3'd4;
   localparam logic [2:0] S_TAIL   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         rcnt_ff, rcnt_in;
   logic [CW-1:0]         tcnt_ff, tcnt_in;
   logic                  ovf_ff, ovf_in;
   logic [TW-1:0]         tlen_ff;
   logic [CW-1:0]         ri_ff, ri_in;
   logic [CW-1:0]         ti_ff, ti_in;
   logic [TW-1:0]         prev_ff, prev_in;
   logic signed [CW:0]    d_ff, d_in;
   logic [SQW-1:0]        sq_ff, sq_in;
   logic signed [GW-1:0]  gap_ff, gap_in;
   logic [SQW-1:0]        fac_ff, fac_in;
   logic                  last_ff, last_in;
   logic                  tail_ff, tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  accept;
   logic [TW-1:0]         req_time;
   logic                  ref_we, test_we;
   logic [TW-1:0]         ref_rdata, test_rdata;
   logic                  take_ref;
   logic [TW-1:0]         pick_time;
   logic signed [SQW:0]   two_d;
   logic signed [SQW:0]   sq_next;
   logic [CW-1:0]         ri_next, ti_next;
   spkd_pkg::mac_ctl_type mac_ctl;
   logic signed [DW-1:0]  mac_sum;

   assign accept   = req_if.valid && req_if.ready;
   assign req_time = req_if.spike_time[TW-1:0];
   assign ref_we   = accept && (req_if.opcode == spkd_pkg::OP_ADD_REF)
                     && (rcnt_ff < CW'(MAX_SPIKES));
   assign test_we  = accept && (req_if.opcode == spkd_pkg::OP_ADD_TEST)
                     && (tcnt_ff < CW'(MAX_SPIKES));

   spkd_ram #(.DEPTH(MAX_SPIKES), .AW(AW), .DW(TW)) u_ref_ram (
      .clock (clock),
      .we    (ref_we),
      .waddr (rcnt_ff[AW-1:0]),
      .wdata (req_time),
      .raddr (ri_ff[AW-1:0]),
      .rdata (ref_rdata)
   );

   spkd_ram #(.DEPTH(MAX_SPIKES), .AW(AW), .DW(TW)) u_test_ram (
      .clock (clock),
      .we    (test_we),
      .waddr (tcnt_ff[AW-1:0]),
      .wdata (req_time),
      .raddr (ti_ff[AW-1:0]),
      .rdata (test_rdata)
   );

   spkd_mac #(.GW(GW), .SQW(SQW)) u_mac (
      .clock (clock),
      .gap   (gap_ff),
      .fac   (fac_ff),
      .ctl   (mac_ctl),
      .sum   (mac_sum)
   );

   // Merge choice: on equal times the reference spike goes first.
   always_comb begin
      take_ref  = (ri_ff < rcnt_ff) && ((ti_ff >= tcnt_ff) || (ref_rdata <= test_rdata));
      pick_time = take_ref ? ref_rdata : test_rdata;
      two_d     = (SQW+1)'(d_ff) <<< 1;
      // (d -/+ 1)^2 = d^2 -/+ 2d + 1
      if (take_ref) begin
         sq_next = $signed({1'b0, sq_ff}) - two_d + (SQW+1)'(1);
      end else begin
         sq_next = $signed({1'b0, sq_ff}) + two_d + (SQW+1)'(1);
      end
      ri_next = take_ref ? ri_ff + CW'(1) : ri_ff;
      ti_next = take_ref ? ti_ff : ti_ff + CW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      rcnt_in      = rcnt_ff;
      tcnt_in      = tcnt_ff;
      ovf_in       = ovf_ff;
      ri_in        = ri_ff;
      ti_in        = ti_ff;
      prev_in      = prev_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      gap_in       = gap_ff;
      fac_in       = fac_ff;
      last_in      = last_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mac_ctl      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_if.opcode)
                  spkd_pkg::OP_ADD_REF: begin
                     if (ref_we) begin
                        rcnt_in = rcnt_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spkd_pkg::OP_ADD_TEST: begin
                     if (test_we) begin
                        tcnt_in = tcnt_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  spkd_pkg::OP_COMPUTE: begin
                     mac_ctl.clear = 1'b1;
                     ri_in   = '0;
                     ti_in   = '0;
                     prev_in = '0;
                     d_in    = '0;
                     sq_in   = '0;
                     tail_in = 1'b0;
                     if ((rcnt_ff == '0) && (tcnt_ff == '0)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rcnt_in = '0;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            gap_in  = $signed(GW'(pick_time)) - $signed(GW'(prev_ff));
            fac_in  = sq_ff;
            sq_in   = sq_next[SQW-1:0];
            d_in    = take_ref ? d_ff - (CW+1)'(1) : d_ff + (CW+1)'(1);
            prev_in = pick_time;
            ri_in   = ri_next;
            ti_in   = ti_next;
            last_in = (ri_next >= rcnt_ff) && (ti_next >= tcnt_ff);
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            mac_ctl.acc = 1'b1;
            state_in    = S_MUL_HI;
         end
         S_MUL_HI: begin
            mac_ctl.acc = 1'b1;
            mac_ctl.hi  = 1'b1;
            if (tail_ff) begin
               state_in = S_DONE;
            end else if (last_ff) begin
               state_in = S_TAIL;
            end else begin
               state_in = S_READ;
            end
         end
         S_TAIL: begin
            gap_in   = $signed(GW'(tlen_ff)) - $signed(GW'(prev_ff));
            fac_in   = sq_ff;
            tail_in  = 1'b1;
            state_in = S_MUL_LO;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = mac_sum;
               rsp_ovf_in   = ovf_ff;
               tcnt_in      = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rcnt_ff      <= '0;
         tcnt_ff      <= '0;
         ovf_ff       <= 1'b0;
         tlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcnt_ff      <= rcnt_in;
         tcnt_ff      <= tcnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            tlen_ff <= csr_wdata[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ri_ff       <= ri_in;
      ti_ff       <= ti_in;
      prev_ff     <= prev_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      gap_ff      <= gap_in;
      fac_ff      <= fac_in;
      last_ff     <= last_in;
      tail_ff     <= tail_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.distance       = rsp_dist_ff;
   assign rsp_if.train_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the spike count difference distance block
// Feeds spike loads, reference clears and compute requests with random gaps
// on both channels, predicts each distance from its own copy of the two
// trains and compares every result item field by field.
// ----------------------------------------------------------------------------

module testbench;

   localparam int TRAIN_DEPTH  = 64;
   localparam int PHASE_ITEMS  = 300;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int HOLD_CYCLES  = 1500;

   typedef struct packed {
      logic [spkd_pkg::OPCODE_W-1:0] opcode;
      logic [spkd_pkg::SPIKE_W-1:0]  spike_time;
   } request_item_type;

   typedef struct packed {
      logic [spkd_pkg::DIST_W-1:0] distance;
      logic                        overflow;
   } distance_result_type;

   typedef logic [spkd_pkg::SPIKE_W-1:0] time_list_type[$];

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [spkd_pkg::SPIKE_W-1:0]  csr_wdata;

   spkd_req_if req_ch ();
   spkd_rsp_if rsp_ch ();

   spike_count_difference_distance_top #(
      .MAX_SPIKES (TRAIN_DEPTH),
      .TIME_BITS  (spkd_pkg::SPIKE_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   request_item_type     pending_requests[$];
   distance_result_type  expected_distances[$];
   int                   requests_queued = 0;
   int                   mismatch_count  = 0;
   int                   cycle_count     = 0;
   bit                   item_taken      = 1'b0;
   bit                   steady_flow     = 1'b0;
   bit                   hold_armed      = 1'b0;
   int                   hold_left       = 0;

   // Predictor state: both trains, their lengths, the drop flag and the window.
   logic [spkd_pkg::SPIKE_W-1:0] ref_train  [TRAIN_DEPTH];
   logic [spkd_pkg::SPIKE_W-1:0] test_train [TRAIN_DEPTH];
   int                           ref_len    = 0;
   int                           test_len   = 0;
   bit                           dropped    = 1'b0;
   logic [spkd_pkg::SPIKE_W-1:0] window_end = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   // Integral of the squared running count difference, wrapped to the
   // result width. Reference spikes win ties.
   function automatic logic [spkd_pkg::DIST_W-1:0] integrate_count_gap();
      int         ri    = 0;
      int         ti    = 0;
      int         level = 0;
      bit         take_ref;
      bit [63:0]  last  = '0;
      bit [63:0]  area  = '0;
      bit [63:0]  here;
      bit [63:0]  sq;
      if (ref_len == 0 && test_len == 0) begin
         return '0;
      end
      while (ri < ref_len || ti < test_len) begin
         take_ref = (ri < ref_len) &&
                    (ti >= test_len || ref_train[ri] <= test_train[ti]);
         here = take_ref ? 64'(ref_train[ri]) : 64'(test_train[ti]);
         sq = 64'(level * level);
         area += (here - last) * sq;
         if (take_ref) begin
            level--;
            ri++;
         end else begin
            level++;
            ti++;
         end
         last = here;
      end
      sq = 64'(level * level);
      area += (64'(window_end) - last) * sq;
      return area[spkd_pkg::DIST_W-1:0];
   endfunction

   function automatic void apply_request(request_item_type item);
      distance_result_type outcome;
      case (item.opcode)
         spkd_pkg::OP_ADD_REF: begin
            if (ref_len >= TRAIN_DEPTH) begin
               dropped = 1'b1;
            end else begin
               ref_train[ref_len] = item.spike_time;
               ref_len++;
            end
         end
         spkd_pkg::OP_ADD_TEST: begin
            if (test_len >= TRAIN_DEPTH) begin
               dropped = 1'b1;
            end else begin
               test_train[test_len] = item.spike_time;
               test_len++;
            end
         end
         spkd_pkg::OP_COMPUTE: begin
            outcome.distance = integrate_count_gap();
            outcome.overflow = dropped;
            expected_distances.push_back(outcome);
            test_len = 0;
            dropped  = 1'b0;
         end
         default: begin
            ref_len = 0;
         end
      endcase
   endfunction

   // Request side: hold an offered item until it is taken, then decide anew.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !item_taken)) begin
         if (pending_requests.size() > 0 && (steady_flow || $urandom_range(99) >= 31)) begin
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= pending_requests[0].opcode;
            req_ch.spike_time <= pending_requests[0].spike_time;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      item_taken = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         apply_request(pending_requests.pop_front());
         item_taken = 1'b1;
      end
   end

   // Result side: random stalls, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_flow || $urandom_range(99) >= 31;
      end
   end

   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected result distance=%0d", rsp_ch.distance));
         end else begin
            want = expected_distances.pop_front();
            if (rsp_ch.distance !== want.distance)
               report_mismatch($sformatf("distance got %h want %h",
                                         rsp_ch.distance, want.distance));
            if (rsp_ch.train_overflow !== want.overflow)
               report_mismatch($sformatf("train_overflow got %b want %b",
                                         rsp_ch.train_overflow, want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_request(logic [spkd_pkg::OPCODE_W-1:0] opcode,
                                logic [spkd_pkg::SPIKE_W-1:0] spike_time);
      request_item_type item;
      item.opcode     = opcode;
      item.spike_time = spike_time;
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   task automatic write_time_length(logic [spkd_pkg::SPIKE_W-1:0] ticks);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= ticks;
      @(negedge clock);
      csr_we    <= 1'b0;
      window_end = ticks;
   endtask

   // Wait until every item is taken and every result is back, then let
   // trailing loads finish.
   task automatic settle(int quiet_cycles);
      while (pending_requests.size() != 0 || expected_distances.size() != 0)
         @(posedge clock);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   // Mostly short trains; now and then one long enough to overflow.
   function automatic int train_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)
         return $urandom_range(TRAIN_DEPTH - 4, TRAIN_DEPTH + 6);
      else if (pick < 15)
         return $urandom_range(7, 20);
      return $urandom_range(0, 6);
   endfunction

   function automatic time_list_type sorted_times(int count,
                                                  logic [spkd_pkg::SPIKE_W-1:0] span);
      time_list_type                times;
      logic [spkd_pkg::SPIKE_W:0]   sum;
      logic [spkd_pkg::SPIKE_W-1:0] prev;
      int                           pick;
      prev = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(span);
      for (int i = 0; i < count; i++) begin
         times.push_back(prev);
         pick = $urandom_range(99);
         if (pick < 10)
            sum = prev;
         else if (pick < 92)
            sum = prev + $urandom_range(span);
         else
            sum = prev + ($urandom() >> $urandom_range(31));
         prev = sum[spkd_pkg::SPIKE_W] ? '1 : sum[spkd_pkg::SPIKE_W-1:0];
      end
      return times;
   endfunction

   // One well-formed session (reference kept over a few test trains), or
   // a short burst of arbitrary items.
   task automatic queue_episode(logic [spkd_pkg::SPIKE_W-1:0] span);
      time_list_type ref_times;
      time_list_type test_times;
      int            op_pick;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 10)) begin
            op_pick = $urandom_range(spkd_pkg::OP_CLEAR_REF, spkd_pkg::OP_ADD_REF);
            queue_request(op_pick[spkd_pkg::OPCODE_W-1:0], $urandom());
         end
      end else begin
         if ($urandom_range(1) == 1)
            queue_request(spkd_pkg::OP_CLEAR_REF, $urandom());
         ref_times = sorted_times(train_length(), span);
         repeat ($urandom_range(1, 3)) begin
            test_times = sorted_times(train_length(), span);
            while (ref_times.size() > 0 || test_times.size() > 0) begin
               if (ref_times.size() > 0 && (test_times.size() == 0 || $urandom_range(1) == 1))
                  queue_request(spkd_pkg::OP_ADD_REF, ref_times.pop_front());
               else
                  queue_request(spkd_pkg::OP_ADD_TEST, test_times.pop_front());
            end
            queue_request(spkd_pkg::OP_COMPUTE, $urandom());
         end
      end
   endtask

   task automatic run_random_phase(logic [spkd_pkg::SPIKE_W-1:0] ticks, bit no_gaps,
                                   bit with_hold);
      int                           start;
      logic [spkd_pkg::SPIKE_W-1:0] span;
      write_time_length(ticks);
      span = (ticks == 0) ? 125 : ((ticks < 8) ? 1 : ticks / 8);
      steady_flow = no_gaps;
      hold_armed  = with_hold;
      start = requests_queued;
      while (requests_queued - start < PHASE_ITEMS)
         queue_episode(span);
      settle(20);
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = spkd_pkg::OP_ADD_REF;
      req_ch.spike_time = '0;
      rsp_ch.ready      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Both trains empty right after reset.
      queue_request(spkd_pkg::OP_COMPUTE, '1);
      settle(20);

      write_time_length(32'd1000);
      // Tie between a reference and a test spike.
      queue_request(spkd_pkg::OP_ADD_REF, 32'd100);
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd50);
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd300);
      queue_request(spkd_pkg::OP_ADD_REF, 32'd300);
      queue_request(spkd_pkg::OP_COMPUTE, '0);
      // A spike past the window end gives a negative tail.
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd2000);
      queue_request(spkd_pkg::OP_COMPUTE, 32'h5555_5555);
      // Test spikes out of order.
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd500);
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd200);
      queue_request(spkd_pkg::OP_COMPUTE, 32'hAAAA_AAAA);
      // Extreme times on both trains.
      queue_request(spkd_pkg::OP_ADD_REF, '1);
      queue_request(spkd_pkg::OP_ADD_TEST, '0);
      queue_request(spkd_pkg::OP_ADD_TEST, '1);
      queue_request(spkd_pkg::OP_COMPUTE, '1);
      queue_request(spkd_pkg::OP_CLEAR_REF, '1);
      queue_request(spkd_pkg::OP_COMPUTE, '0);
      queue_request(spkd_pkg::OP_ADD_TEST, 32'd999);
      queue_request(spkd_pkg::OP_COMPUTE, '0);
      settle(20);

      run_random_phase(32'hFFFF_FFFF, 1'b0, 1'b0);
      run_random_phase(32'd0,         1'b1, 1'b0);
      run_random_phase(32'd1000,      1'b0, 1'b1);
      run_random_phase($urandom(),    1'b0, 1'b0);
      run_random_phase(32'd250000,    1'b0, 1'b0);
      run_random_phase(32'h8000_0000, 1'b0, 1'b0);

      steady_flow = 1'b0;
      settle(50);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/spkd_pkg.sv
sv/spkd_if.sv
sv/spkd_ram.sv
sv/spkd_mac.sv
sv/spike_count_difference_distance_top.sv
bench/testbench.sv
